/* rtl/irpc_pkg.sv */
// irpc_pkg: shared types, codes, constants and crc-8 helpers for the pec retry checker
// used by irpc_front, irpc_queue, irpc_back and the top level; depends on nothing
`default_nettype none

package irpc_pkg;

	localparam int CHANNELS    = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0]  CRC_POLY     = 8'h07;
	localparam logic [7:0]  READ_BIT     = 8'h01;
	localparam logic [16:0] TEMP_OFFSET  = 17'd27315;
	localparam logic [7:0]  ADDR_RESET   = 8'd180;
	localparam logic [7:0]  CMD_RESET    = 8'd7;
	localparam logic [2:0]  RETRY_RESET  = 3'd2;

	typedef enum logic [1:0] {
		OP_SCAN      = 2'd0,
		OP_MUX_FAIL  = 2'd1,
		OP_READ_FAIL = 2'd2,
		OP_RESPONSE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_MUX     = 3'd2,
		ST_READ    = 3'd3,
		ST_PEC     = 3'd4,
		ST_DATA    = 3'd5
	} status_t;

	typedef enum logic [7:0] {
		CFG_DEVICE_ADDR = 8'd0,
		CFG_COMMAND     = 8'd1,
		CFG_MAX_RETRIES = 8'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CLS_SCAN    = 2'd0,
		CLS_INVALID = 2'd1,
		CLS_FAIL    = 2'd2,
		CLS_GOOD    = 2'd3
	} cls_t;

	// classified item handed from front to back
	typedef struct packed {
		cls_t        cls;
		status_t     kind;
		logic [7:0]  channel;
		logic [14:0] raw;
		logic [7:0]  flags;
	} entry_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// crc over write address, command and read address
	function automatic logic [7:0] crc8_prefix(input logic [7:0] addr, input logic [7:0] cmd);
		return crc8_byte(crc8_byte(crc8_byte(8'h00, addr), cmd), addr | READ_BIT);
	endfunction

endpackage

`default_nettype wire

/* rtl/irpc_in_if.sv */
// irpc_in_if: valid/ready channel carrying one bus-attempt outcome
// no dependencies
`default_nettype none

interface irpc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] channel;
	logic [7:0] data_low;
	logic [7:0] data_high;
	logic [7:0] pec_byte;
	logic [7:0] bus_error_flags;

	modport source (
		output valid, operation, channel, data_low, data_high, pec_byte, bus_error_flags,
		input  ready
	);
	modport sink (
		input  valid, operation, channel, data_low, data_high, pec_byte, bus_error_flags,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/irpc_out_if.sv */
// irpc_out_if: valid/ready channel carrying one read result with scan aggregates
// no dependencies
`default_nettype none

interface irpc_out_if;
	logic               valid;
	logic               ready;
	logic [7:0]         result_channel;
	logic [2:0]         status;
	logic [2:0]         attempt_index;
	logic signed [16:0] temperature_centi;
	logic [14:0]        raw_value;
	logic [7:0]         attempt_error_flags;
	logic [7:0]         scan_failed_mask;
	logic [2:0]         scan_first_status;
	logic [7:0]         scan_first_channel;
	logic [7:0]         scan_error_flags;

	modport source (
		output valid, result_channel, status, attempt_index, temperature_centi, raw_value,
		       attempt_error_flags, scan_failed_mask, scan_first_status, scan_first_channel,
		       scan_error_flags,
		input  ready
	);
	modport sink (
		input  valid, result_channel, status, attempt_index, temperature_centi, raw_value,
		       attempt_error_flags, scan_failed_mask, scan_first_status, scan_first_channel,
		       scan_error_flags,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/irpc_cfg_if.sv */
// irpc_cfg_if: configuration write channel with register index and data
// no dependencies
`default_nettype none

interface irpc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/irpc_front.sv */
// irpc_front: accepts input transfers, checks pec and classifies each item
// depends on irpc_pkg and irpc_in_if
`default_nettype none

module irpc_front (
	irpc_in_if.sink         item,
	input  wire logic [7:0] crc_prefix,
	input  wire logic       queue_full,
	output irpc_pkg::entry_t entry,
	output logic            push
);

	logic [7:0] crc;

	assign item.ready = !queue_full;
	assign push       = item.valid && !queue_full;

	always_comb begin
		crc           = irpc_pkg::crc8_byte(irpc_pkg::crc8_byte(crc_prefix, item.data_low),
		                                    item.data_high);
		entry.cls     = irpc_pkg::CLS_SCAN;
		entry.kind    = irpc_pkg::ST_OK;
		entry.channel = item.channel;
		entry.raw     = {item.data_high[6:0], item.data_low};
		entry.flags   = 8'd0;
		if (irpc_pkg::op_t'(item.operation) == irpc_pkg::OP_SCAN) begin
			entry.cls = irpc_pkg::CLS_SCAN;
		end else if (item.channel >= 8'(irpc_pkg::CHANNELS)) begin
			entry.cls  = irpc_pkg::CLS_INVALID;
			entry.kind = irpc_pkg::ST_INVALID;
		end else begin
			unique case (irpc_pkg::op_t'(item.operation))
				irpc_pkg::OP_MUX_FAIL: begin
					entry.cls   = irpc_pkg::CLS_FAIL;
					entry.kind  = irpc_pkg::ST_MUX;
					entry.flags = item.bus_error_flags;
				end
				irpc_pkg::OP_READ_FAIL: begin
					entry.cls   = irpc_pkg::CLS_FAIL;
					entry.kind  = irpc_pkg::ST_READ;
					entry.flags = item.bus_error_flags;
				end
				irpc_pkg::OP_RESPONSE: begin
					if (crc != item.pec_byte) begin
						entry.cls  = irpc_pkg::CLS_FAIL;
						entry.kind = irpc_pkg::ST_PEC;
					end else if (item.data_high[7]) begin
						entry.cls  = irpc_pkg::CLS_FAIL;
						entry.kind = irpc_pkg::ST_DATA;
					end else begin
						entry.cls = irpc_pkg::CLS_GOOD;
					end
				end
				default: begin
					entry.cls = irpc_pkg::CLS_SCAN;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/irpc_queue.sv */
// irpc_queue: short fifo of classified items between front and back
// depends on irpc_pkg
`default_nettype none

module irpc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire irpc_pkg::entry_t push_data,
	input  wire logic             pop,
	output irpc_pkg::entry_t      pop_data,
	output logic                  full,
	output logic                  empty
);

	irpc_pkg::entry_t                 mem_q [irpc_pkg::QUEUE_DEPTH];
	logic [irpc_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [irpc_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [irpc_pkg::QUEUE_CW-1:0]    count_q;

	localparam logic [irpc_pkg::QUEUE_AW-1:0] LAST = irpc_pkg::QUEUE_AW'(irpc_pkg::QUEUE_DEPTH - 1);

	assign full     = count_q == irpc_pkg::QUEUE_CW'(irpc_pkg::QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/irpc_back.sv */
// irpc_back: retry counting, scan aggregates and the registered result stage
// depends on irpc_pkg and irpc_out_if
`default_nettype none

module irpc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire irpc_pkg::entry_t entry,
	input  wire logic             entry_valid,
	input  wire logic [2:0]       max_retries,
	output logic                  pop,
	irpc_out_if.source            result
);

	logic [2:0]        attempt_q, attempt_d;
	logic [7:0]        acc_flags_q, acc_flags_d;
	logic              scan_has_fail_q, scan_has_fail_d;
	irpc_pkg::status_t scan_first_kind_q, scan_first_kind_d;
	logic [7:0]        scan_first_chan_q, scan_first_chan_d;
	logic [7:0]        scan_fail_bits_q, scan_fail_bits_d;
	logic [7:0]        scan_flag_bits_q, scan_flag_bits_d;

	logic              emit;
	logic              note;
	logic              note_mask;
	logic [7:0]        note_flags;
	logic [7:0]        acc_or;
	irpc_pkg::status_t res_status;
	logic [2:0]        res_retry;
	logic [16:0]       res_temp;
	logic [14:0]       res_raw;
	logic [7:0]        res_flags;

	logic              out_valid_q;
	logic [7:0]        out_channel_q;
	logic [2:0]        out_status_q;
	logic [2:0]        out_retry_q;
	logic [16:0]       out_temp_q;
	logic [14:0]       out_raw_q;
	logic [7:0]        out_flags_q;
	logic [7:0]        out_mask_q;
	logic [2:0]        out_first_status_q;
	logic [7:0]        out_first_chan_q;
	logic [7:0]        out_scan_flags_q;

	assign pop = entry_valid && (!out_valid_q || result.ready);

	always_comb begin
		attempt_d         = attempt_q;
		acc_flags_d       = acc_flags_q;
		scan_has_fail_d   = scan_has_fail_q;
		scan_first_kind_d = scan_first_kind_q;
		scan_first_chan_d = scan_first_chan_q;
		scan_fail_bits_d  = scan_fail_bits_q;
		scan_flag_bits_d  = scan_flag_bits_q;
		emit              = 1'b0;
		note              = 1'b0;
		note_mask         = 1'b0;
		note_flags        = 8'd0;
		acc_or            = acc_flags_q | entry.flags;
		res_status        = irpc_pkg::ST_OK;
		res_retry         = attempt_q;
		res_temp          = 17'd0;
		res_raw           = 15'd0;
		res_flags         = acc_flags_q;

		unique case (entry.cls)
			irpc_pkg::CLS_SCAN: begin
				attempt_d         = 3'd0;
				acc_flags_d       = 8'd0;
				scan_has_fail_d   = 1'b0;
				scan_first_kind_d = irpc_pkg::ST_OK;
				scan_first_chan_d = 8'd0;
				scan_fail_bits_d  = 8'd0;
				scan_flag_bits_d  = 8'd0;
			end
			irpc_pkg::CLS_INVALID: begin
				attempt_d   = 3'd0;
				acc_flags_d = 8'd0;
				emit        = 1'b1;
				note        = 1'b1;
				res_status  = irpc_pkg::ST_INVALID;
				res_retry   = 3'd0;
				res_flags   = 8'd0;
			end
			irpc_pkg::CLS_FAIL: begin
				if (attempt_q >= max_retries) begin
					attempt_d   = 3'd0;
					acc_flags_d = 8'd0;
					emit        = 1'b1;
					note        = 1'b1;
					note_mask   = 1'b1;
					note_flags  = acc_or;
					res_status  = entry.kind;
					res_flags   = acc_or;
				end else begin
					attempt_d   = attempt_q + 3'd1;
					acc_flags_d = acc_or;
				end
			end
			irpc_pkg::CLS_GOOD: begin
				attempt_d   = 3'd0;
				acc_flags_d = 8'd0;
				emit        = 1'b1;
				res_temp    = {1'b0, entry.raw, 1'b0} - irpc_pkg::TEMP_OFFSET;
				res_raw     = entry.raw;
			end
			default: begin
				attempt_d = attempt_q;
			end
		endcase

		if (note) begin
			if (!scan_has_fail_q) begin
				scan_has_fail_d   = 1'b1;
				scan_first_kind_d = entry.kind;
				scan_first_chan_d = entry.channel;
			end
			if (note_mask) begin
				scan_fail_bits_d = scan_fail_bits_q | (8'd1 << entry.channel[2:0]);
			end
			scan_flag_bits_d = scan_flag_bits_q | note_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_q         <= 3'd0;
			acc_flags_q       <= 8'd0;
			scan_has_fail_q   <= 1'b0;
			scan_first_kind_q <= irpc_pkg::ST_OK;
			scan_first_chan_q <= 8'd0;
			scan_fail_bits_q  <= 8'd0;
			scan_flag_bits_q  <= 8'd0;
			out_valid_q       <= 1'b0;
		end else begin
			if (pop) begin
				attempt_q         <= attempt_d;
				acc_flags_q       <= acc_flags_d;
				scan_has_fail_q   <= scan_has_fail_d;
				scan_first_kind_q <= scan_first_kind_d;
				scan_first_chan_q <= scan_first_chan_d;
				scan_fail_bits_q  <= scan_fail_bits_d;
				scan_flag_bits_q  <= scan_flag_bits_d;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_channel_q      <= entry.channel;
			out_status_q       <= res_status;
			out_retry_q        <= res_retry;
			out_temp_q         <= res_temp;
			out_raw_q          <= res_raw;
			out_flags_q        <= res_flags;
			out_mask_q         <= scan_fail_bits_d;
			out_first_status_q <= scan_first_kind_d;
			out_first_chan_q   <= scan_first_chan_d;
			out_scan_flags_q   <= scan_flag_bits_d;
		end
	end

	assign result.valid               = out_valid_q;
	assign result.result_channel      = out_channel_q;
	assign result.status              = out_status_q;
	assign result.attempt_index       = out_retry_q;
	assign result.temperature_centi   = $signed(out_temp_q);
	assign result.raw_value           = out_raw_q;
	assign result.attempt_error_flags = out_flags_q;
	assign result.scan_failed_mask    = out_mask_q;
	assign result.scan_first_status   = out_first_status_q;
	assign result.scan_first_channel  = out_first_chan_q;
	assign result.scan_error_flags    = out_scan_flags_q;

endmodule

`default_nettype wire

/* rtl/ir_sensor_read_pec_retry_checker.sv */
// ir_sensor_read_pec_retry_checker: top level with config registers, front, queue and back
// path: an item is written into the queue; its result is registered once the output is free
// throughput: one item per cycle while the queue has room; it takes two while a result waits
// the back stage retires one queued item per cycle whenever the output register is free
// reset: arst_n clears all attempt and scan state and loads the default configuration
// depends on irpc_pkg, irpc_in_if, irpc_out_if, irpc_cfg_if, irpc_front, irpc_queue, irpc_back
`default_nettype none

module ir_sensor_read_pec_retry_checker (
	input  wire logic  clk,
	input  wire logic  arst_n,
	irpc_in_if.sink    item,
	irpc_out_if.source result,
	irpc_cfg_if.sink   cfg
);

	logic [7:0] dev_addr_q, dev_addr_d;
	logic [7:0] command_q, command_d;
	logic [2:0] max_retries_q;
	logic [7:0] crc_prefix_q;
	logic       cfg_write;

	irpc_pkg::entry_t front_entry;
	irpc_pkg::entry_t queue_entry;
	logic             push;
	logic             pop;
	logic             queue_full;
	logic             queue_empty;

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid;

	always_comb begin
		dev_addr_d = dev_addr_q;
		command_d  = command_q;
		if (cfg_write && cfg.index == irpc_pkg::CFG_DEVICE_ADDR) begin
			dev_addr_d = cfg.data;
		end
		if (cfg_write && cfg.index == irpc_pkg::CFG_COMMAND) begin
			command_d = cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q    <= irpc_pkg::ADDR_RESET;
			command_q     <= irpc_pkg::CMD_RESET;
			max_retries_q <= irpc_pkg::RETRY_RESET;
			crc_prefix_q  <= irpc_pkg::crc8_prefix(irpc_pkg::ADDR_RESET, irpc_pkg::CMD_RESET);
		end else if (cfg_write) begin
			dev_addr_q   <= dev_addr_d;
			command_q    <= command_d;
			crc_prefix_q <= irpc_pkg::crc8_prefix(dev_addr_d, command_d);
			if (cfg.index == irpc_pkg::CFG_MAX_RETRIES) begin
				max_retries_q <= cfg.data[2:0];
			end
		end
	end

	irpc_front u_front (
		.item       (item),
		.crc_prefix (crc_prefix_q),
		.queue_full (queue_full),
		.entry      (front_entry),
		.push       (push)
	);

	irpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_entry),
		.pop       (pop),
		.pop_data  (queue_entry),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	irpc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (queue_entry),
		.entry_valid (!queue_empty),
		.max_retries (max_retries_q),
		.pop         (pop),
		.result      (result)
	);

endmodule

`default_nettype wire
